/* hw/rtl/ssrs_pkg.sv */
// Shared types, constants and code classifiers for the secondary structure
// run segmenter. No dependencies; every other RTL file refers to this package.
`default_nettype none

package ssrs_pkg;

    localparam int POSITION_BITS = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CODE_COIL      = 8'h43; // 'C'
    localparam logic [7:0] CODE_BRIDGE    = 8'h42; // 'B'
    localparam logic [7:0] CODE_BRIDGE_LC = 8'h62; // 'b'
    localparam logic [7:0] CODE_TURN      = 8'h54; // 'T'
    localparam logic [7:0] CODE_DOT       = 8'h2E; // '.'
    localparam logic [7:0] CODE_ALPHA     = 8'h48; // 'H'
    localparam logic [7:0] CODE_THREE_TEN = 8'h47; // 'G'
    localparam logic [7:0] CODE_PI        = 8'h49; // 'I'
    localparam logic [7:0] CODE_SPACE     = 8'h20; // ' '

    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One queue entry: everything the back end needs to emit the records
    // caused by one input item.
    typedef struct packed {
        logic                     has_elem;
        logic                     has_sum;
        logic [15:0]              elem_num;
        logic [POSITION_BITS-1:0] start_pos;
        logic [POSITION_BITS-1:0] end_pos;
        logic                     is_helix;
        logic [15:0]              helix_cnt;
        logic [15:0]              strand_cnt;
    } ssrs_cmd_t;

    function automatic logic is_breaker(input logic [7:0] code);
        return code inside {CODE_COIL, CODE_BRIDGE, CODE_BRIDGE_LC, CODE_TURN, CODE_DOT};
    endfunction

    function automatic logic is_helix_code(input logic [7:0] code);
        return code inside {CODE_ALPHA, CODE_THREE_TEN, CODE_PI};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ssrs_front.sv */
// Front end: accepts atoms, tracks the open run and decides which records
// each atom causes. Uses ssrs_pkg for codes and the queue entry type.
`default_nettype none

module ssrs_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [9:0]          cfg_wr_data,
    input  wire logic                in_valid,
    input  wire logic                q_full,
    input  wire logic [7:0]          structure_code,
    input  wire logic [15:0]         residue_number,
    input  wire logic                chain_end,
    output logic                     push,
    output ssrs_pkg::ssrs_cmd_t      cmd
);

    localparam int P = ssrs_pkg::POSITION_BITS;

    logic [9:0]   min_size_reg;
    logic         in_elem_reg,   in_elem_next;
    logic [7:0]   elem_type_reg, elem_type_next;
    logic [P-1:0] run_start_reg, run_start_next;
    logic [15:0]  run_size_reg,  run_size_next;
    logic [15:0]  next_num_reg,  next_num_next;
    logic [15:0]  prev_res_reg;
    logic [P-1:0] atom_pos_reg,  atom_pos_next;
    logic [15:0]  helices_reg,   helices_next;
    logic [15:0]  strands_reg,   strands_next;

    logic         accept;
    logic         emit;
    logic [P-1:0] end_pos;
    logic [P-1:0] prev_pos;
    logic [16:0]  succ;
    logic         res_step;
    logic         res_jump;
    logic [15:0]  grown;
    logic         helix;

    assign accept   = in_valid & ~q_full;
    assign prev_pos = atom_pos_reg - 1'b1;
    assign succ     = {1'b0, prev_res_reg} + 17'd1;
    assign res_step = ({1'b0, residue_number} == succ);
    assign res_jump = ({1'b0, residue_number} > succ);
    assign grown    = (res_step && run_size_reg != 16'hFFFF) ? run_size_reg + 16'd1
                                                             : run_size_reg;
    assign helix    = ssrs_pkg::is_helix_code(elem_type_reg);

    always_comb
    begin
        emit           = 1'b0;
        end_pos        = prev_pos;
        in_elem_next   = in_elem_reg;
        elem_type_next = elem_type_reg;
        run_start_next = run_start_reg;
        run_size_next  = run_size_reg;

        if (ssrs_pkg::is_breaker(structure_code))
        begin
            if (in_elem_reg)
            begin
                emit          = (run_size_reg >= {6'd0, min_size_reg});
                in_elem_next  = 1'b0;
                run_size_next = 16'd0;
            end
        end
        else if (in_elem_reg)
        begin
            if (structure_code != elem_type_reg)
            begin
                emit           = (run_size_reg >= {6'd0, min_size_reg});
                run_start_next = atom_pos_reg;
                run_size_next  = 16'd1;
                elem_type_next = structure_code;
            end
            else if (res_jump)
            begin
                emit           = (run_size_reg >= {6'd0, min_size_reg});
                run_start_next = atom_pos_reg;
                run_size_next  = 16'd1;
            end
            else
            begin
                run_size_next = grown;
                // The last atom of a chain closes a run that it continues.
                if (chain_end && grown >= {6'd0, min_size_reg})
                begin
                    emit    = 1'b1;
                    end_pos = atom_pos_reg;
                end
            end
        end
        else
        begin
            run_start_next = atom_pos_reg;
            elem_type_next = structure_code;
            in_elem_next   = 1'b1;
            run_size_next  = 16'd1;
        end

        next_num_next = next_num_reg;
        helices_next  = helices_reg;
        strands_next  = strands_reg;
        if (emit)
        begin
            next_num_next = next_num_reg + 16'd1;
            if (helix && helices_reg != 16'hFFFF)
            begin
                helices_next = helices_reg + 16'd1;
            end
            if (!helix && strands_reg != 16'hFFFF)
            begin
                strands_next = strands_reg + 16'd1;
            end
        end
        atom_pos_next = atom_pos_reg + 1'b1;

        cmd.has_elem   = emit;
        cmd.has_sum    = chain_end;
        cmd.elem_num   = next_num_reg;
        cmd.start_pos  = run_start_reg;
        cmd.end_pos    = end_pos;
        cmd.is_helix   = helix;
        cmd.helix_cnt  = helices_next;
        cmd.strand_cnt = strands_next;
    end

    assign push = accept & (emit | chain_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_size_reg <= 10'd1;
        end
        else if (cfg_wr_en)
        begin
            min_size_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_elem_reg   <= 1'b0;
            elem_type_reg <= ssrs_pkg::CODE_SPACE;
            run_start_reg <= '0;
            run_size_reg  <= 16'd0;
            next_num_reg  <= 16'd1;
            prev_res_reg  <= 16'd0;
            atom_pos_reg  <= '0;
            helices_reg   <= 16'd0;
            strands_reg   <= 16'd0;
        end
        else if (accept)
        begin
            prev_res_reg <= residue_number;
            if (chain_end)
            begin
                // The chain is finished: start the next one from scratch.
                in_elem_reg   <= 1'b0;
                elem_type_reg <= ssrs_pkg::CODE_SPACE;
                run_start_reg <= '0;
                run_size_reg  <= 16'd0;
                next_num_reg  <= 16'd1;
                atom_pos_reg  <= '0;
                helices_reg   <= 16'd0;
                strands_reg   <= 16'd0;
            end
            else
            begin
                in_elem_reg   <= in_elem_next;
                elem_type_reg <= elem_type_next;
                run_start_reg <= run_start_next;
                run_size_reg  <= run_size_next;
                next_num_reg  <= next_num_next;
                atom_pos_reg  <= atom_pos_next;
                helices_reg   <= helices_next;
                strands_reg   <= strands_next;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ssrs_queue.sv */
// Short queue of record commands between the front and back ends.
// Depth and entry type come from ssrs_pkg.
`default_nettype none

module ssrs_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire ssrs_pkg::ssrs_cmd_t push_cmd,
    input  wire logic                pop,
    output logic                     full,
    output logic                     not_empty,
    output ssrs_pkg::ssrs_cmd_t      head
);

    localparam int D = ssrs_pkg::QUEUE_DEPTH;

    ssrs_pkg::ssrs_cmd_t                 entry_reg [D];
    logic [ssrs_pkg::QPTR_BITS-1:0]      wr_ptr_reg;
    logic [ssrs_pkg::QPTR_BITS-1:0]      rd_ptr_reg;
    logic [ssrs_pkg::QCNT_BITS-1:0]      count_reg;
    logic                                do_pop;

    assign full      = (count_reg == ssrs_pkg::QCNT_BITS'(D));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_pop    = pop & not_empty;

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == ssrs_pkg::QPTR_BITS'(D - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == ssrs_pkg::QPTR_BITS'(D - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ssrs_back.sv */
// Back end: turns queue commands into element and summary records and
// holds them in the output register. Uses ssrs_pkg for the entry type.
`default_nettype none

module ssrs_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_not_empty,
    input  wire ssrs_pkg::ssrs_cmd_t head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     kind,
    output logic [15:0]              element_number,
    output logic [15:0]              start_position,
    output logic [15:0]              end_position,
    output logic                     is_helix,
    output logic [15:0]              helix_count,
    output logic [15:0]              strand_count,
    output logic                     last
);

    logic        out_valid_reg;
    logic        phase_reg, phase_next;
    logic        load;
    logic        send_elem;
    logic        kind_reg;
    logic [15:0] elem_num_reg;
    logic [15:0] start_reg;
    logic [15:0] end_reg;
    logic        helix_reg;
    logic [15:0] helix_cnt_reg;
    logic [15:0] strand_cnt_reg;
    logic        last_reg;

    assign load      = q_not_empty & (~out_valid_reg | ~out_stall);
    // The element record of an entry goes first; phase marks it as sent.
    assign send_elem = head.has_elem & ~phase_reg;

    always_comb
    begin
        pop        = 1'b0;
        phase_next = phase_reg;
        if (load)
        begin
            if (send_elem && head.has_sum)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                pop        = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (send_elem)
            begin
                kind_reg       <= ssrs_pkg::KIND_ELEMENT;
                elem_num_reg   <= head.elem_num;
                start_reg      <= 16'(head.start_pos);
                end_reg        <= 16'(head.end_pos);
                helix_reg      <= head.is_helix;
                helix_cnt_reg  <= 16'd0;
                strand_cnt_reg <= 16'd0;
                last_reg       <= ~head.has_sum;
            end
            else
            begin
                kind_reg       <= ssrs_pkg::KIND_SUMMARY;
                elem_num_reg   <= 16'd0;
                start_reg      <= 16'd0;
                end_reg        <= 16'd0;
                helix_reg      <= 1'b0;
                helix_cnt_reg  <= head.helix_cnt;
                strand_cnt_reg <= head.strand_cnt;
                last_reg       <= 1'b1;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign element_number = elem_num_reg;
    assign start_position = start_reg;
    assign end_position   = end_reg;
    assign is_helix       = helix_reg;
    assign helix_count    = helix_cnt_reg;
    assign strand_count   = strand_cnt_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/secondary_structure_run_segmenter.sv */
// Secondary structure run segmenter, top level: front end, command queue, back end.
// Path: a record is written into the command queue when its atom is accepted, then
// loaded into the output register, where it waits until out_stall is low.
// Throughput: one atom per cycle while in_stall is low; an atom that yields an element
// and a chain summary sends both in turn; the command queue absorbs the burst.
// Reset (rst_n, asynchronous): run state cleared, element numbering at 1, minimum
// element size 1, queue and output register empty.
`default_nettype none

module secondary_structure_run_segmenter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [9:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  structure_code,
    input  wire logic [15:0] residue_number,
    input  wire logic        chain_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [15:0]      element_number,
    output logic [15:0]      start_position,
    output logic [15:0]      end_position,
    output logic             is_helix,
    output logic [15:0]      helix_count,
    output logic [15:0]      strand_count,
    output logic             last
);

    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_not_empty;
    ssrs_pkg::ssrs_cmd_t push_cmd;
    ssrs_pkg::ssrs_cmd_t head;

    assign in_stall = q_full;

    ssrs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .q_full         (q_full),
        .structure_code (structure_code),
        .residue_number (residue_number),
        .chain_end      (chain_end),
        .push           (push),
        .cmd            (push_cmd)
    );

    ssrs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    ssrs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .element_number (element_number),
        .start_position (start_position),
        .end_position   (end_position),
        .is_helix       (is_helix),
        .helix_count    (helix_count),
        .strand_count   (strand_count),
        .last           (last)
    );

`ifndef NO_ASSERTIONS
    // A chain summary is always the final record of its atom.
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == ssrs_pkg::KIND_SUMMARY) |-> last)
        else $error("summary record without last");

    // An element record that is not last must be followed at once by its summary.
    a_elem_then_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && kind == ssrs_pkg::KIND_ELEMENT && !last)
            |=> (out_valid && kind == ssrs_pkg::KIND_SUMMARY))
        else $error("element record not followed by its summary");

    // Element records carry no chain counts.
    a_elem_counts_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == ssrs_pkg::KIND_ELEMENT)
            |-> (helix_count == 16'd0 && strand_count == 16'd0))
        else $error("element record with nonzero counts");
`endif

endmodule

`default_nettype wire

/* tb/sv/secondary_structure_run_segmenter_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for secondary_structure_run_segmenter.
// Depends on ssrs_pkg and the segmenter RTL; a built-in run tracker predicts every record.

module secondary_structure_run_segmenter_tb;

    localparam logic [7:0] CODE_STRAND = 8'h45; // 'E'
    localparam int LIMIT_CYCLES = 1000000;

    typedef struct packed {
        logic [7:0]  code;
        logic [15:0] res;
        logic        chain_tail;
    } atom_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] elem_num;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
        logic        helix;
        logic [15:0] helix_cnt;
        logic [15:0] strand_cnt;
        logic        last;
    } segment_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [9:0]  cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  structure_code = '0;
    logic [15:0] residue_number = '0;
    logic        chain_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic [15:0] element_number;
    logic [15:0] start_position;
    logic [15:0] end_position;
    logic        is_helix;
    logic [15:0] helix_count;
    logic [15:0] strand_count;
    logic        last;

    atom_t        atoms_to_send[$];
    segment_rec_t records_due[$];
    int           idle_pct = 17;
    int           mismatch_count = 0;
    int           cycle_count = 0;

    // Run tracker state.
    logic [9:0]  min_size_q;
    logic        in_run;
    logic [7:0]  run_code;
    logic [15:0] run_first;
    logic [15:0] run_len;
    logic [15:0] elem_next;
    logic [15:0] prev_res;
    logic [15:0] atom_pos;
    logic [15:0] helix_tally;
    logic [15:0] strand_tally;

    secondary_structure_run_segmenter u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .structure_code (structure_code),
        .residue_number (residue_number),
        .chain_end      (chain_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .element_number (element_number),
        .start_position (start_position),
        .end_position   (end_position),
        .is_helix       (is_helix),
        .helix_count    (helix_count),
        .strand_count   (strand_count),
        .last           (last)
    );

    always #10 clk = ~clk;

    function automatic logic code_breaks_run(input logic [7:0] code);
        return (code == ssrs_pkg::CODE_COIL) || (code == ssrs_pkg::CODE_BRIDGE) ||
               (code == ssrs_pkg::CODE_BRIDGE_LC) || (code == ssrs_pkg::CODE_TURN) ||
               (code == ssrs_pkg::CODE_DOT);
    endfunction

    function automatic void clear_chain();
        in_run       = 1'b0;
        run_code     = ssrs_pkg::CODE_SPACE;
        run_first    = '0;
        run_len      = '0;
        elem_next    = 16'd1;
        atom_pos     = '0;
        helix_tally  = '0;
        strand_tally = '0;
    endfunction

    // Numbers the open run as an element ending at stop and bumps the chain tallies.
    function automatic segment_rec_t close_segment(input logic [15:0] stop);
        segment_rec_t r;
        logic         helix;
        helix = (run_code == ssrs_pkg::CODE_ALPHA) || (run_code == ssrs_pkg::CODE_THREE_TEN) ||
                (run_code == ssrs_pkg::CODE_PI);
        r = '0;
        r.kind      = ssrs_pkg::KIND_ELEMENT;
        r.elem_num  = elem_next;
        r.start_pos = run_first;
        r.end_pos   = stop;
        r.helix     = helix;
        elem_next   = elem_next + 16'd1;
        if (helix)
        begin
            if (helix_tally != 16'hFFFF)
                helix_tally = helix_tally + 16'd1;
        end
        else if (strand_tally != 16'hFFFF)
        begin
            strand_tally = strand_tally + 16'd1;
        end
        return r;
    endfunction

    function automatic void track_atom(input atom_t a);
        segment_rec_t found;
        segment_rec_t summary;
        logic         have;
        logic [16:0]  succ;
        logic [15:0]  pos;
        logic [15:0]  prev_pos;
        logic [15:0]  min_len;
        have     = 1'b0;
        found    = '0;
        pos      = atom_pos;
        prev_pos = atom_pos - 16'd1;
        min_len  = {6'd0, min_size_q};
        if (code_breaks_run(a.code))
        begin
            if (in_run)
            begin
                if (run_len >= min_len)
                begin
                    found = close_segment(prev_pos);
                    have  = 1'b1;
                end
                in_run  = 1'b0;
                run_len = '0;
            end
        end
        else if (in_run)
        begin
            if (a.code != run_code)
            begin
                if (run_len >= min_len)
                begin
                    found = close_segment(prev_pos);
                    have  = 1'b1;
                end
                run_first = pos;
                run_len   = 16'd1;
                run_code  = a.code;
            end
            else
            begin
                // A residue of 65535 has no successor, so the 17-bit sum never matches.
                succ = {1'b0, prev_res} + 17'd1;
                if ({1'b0, a.res} == succ && run_len != 16'hFFFF)
                    run_len = run_len + 16'd1;
                if ({1'b0, a.res} > succ)
                begin
                    if (run_len >= min_len)
                    begin
                        found = close_segment(prev_pos);
                        have  = 1'b1;
                    end
                    run_len   = 16'd1;
                    run_first = pos;
                end
                else if (a.chain_tail && run_len >= min_len)
                begin
                    found = close_segment(pos);
                    have  = 1'b1;
                end
            end
        end
        else
        begin
            run_first = pos;
            run_code  = a.code;
            in_run    = 1'b1;
            run_len   = 16'd1;
        end
        prev_res = a.res;
        atom_pos = pos + 16'd1;
        if (have)
        begin
            found.last = !a.chain_tail;
            records_due.push_back(found);
        end
        if (a.chain_tail)
        begin
            summary            = '0;
            summary.kind       = ssrs_pkg::KIND_SUMMARY;
            summary.helix_cnt  = helix_tally;
            summary.strand_cnt = strand_tally;
            summary.last       = 1'b1;
            records_due.push_back(summary);
            clear_chain();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        mismatch_count++;
        $display("mismatch on %s: expected %0d, got %0d (cycle %0d)",
                 what, want, got, cycle_count);
    endtask

    // Input side: a new atom is offered once the previous transfer has completed.
    always @(posedge clk or negedge rst_n)
    begin : atom_driver
        atom_t a;
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            structure_code <= '0;
            residue_number <= '0;
            chain_end      <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (atoms_to_send.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                a = atoms_to_send.pop_front();
                in_valid       <= 1'b1;
                structure_code <= a.code;
                residue_number <= a.res;
                chain_end      <= a.chain_tail;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < idle_pct);
    end

    // Records are checked before the atom of the same edge is tracked; a record
    // passes through the command queue and the output register before it comes out.
    always @(posedge clk)
    begin : record_monitor
        segment_rec_t want;
        atom_t        a;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (records_due.size() == 0)
                begin
                    report_mismatch("record with none pending", 16'd0, 16'd0);
                end
                else
                begin
                    want = records_due.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", 16'(want.kind), 16'(kind));
                    if (element_number !== want.elem_num)
                        report_mismatch("element_number", want.elem_num, element_number);
                    if (start_position !== want.start_pos)
                        report_mismatch("start_position", want.start_pos, start_position);
                    if (end_position !== want.end_pos)
                        report_mismatch("end_position", want.end_pos, end_position);
                    if (is_helix !== want.helix)
                        report_mismatch("is_helix", 16'(want.helix), 16'(is_helix));
                    if (helix_count !== want.helix_cnt)
                        report_mismatch("helix_count", want.helix_cnt, helix_count);
                    if (strand_count !== want.strand_cnt)
                        report_mismatch("strand_count", want.strand_cnt, strand_count);
                    if (last !== want.last)
                        report_mismatch("last", 16'(want.last), 16'(last));
                end
            end
            if (in_valid && !in_stall)
            begin
                a.code       = structure_code;
                a.res        = residue_number;
                a.chain_tail = chain_end;
                track_atom(a);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_atom(input logic [7:0] code, input logic [15:0] res,
                              input logic tail);
        atom_t a;
        a.code       = code;
        a.res        = res;
        a.chain_tail = tail;
        atoms_to_send.push_back(a);
    endtask

    // Mostly well-formed chains of runs with random content, mixed with breakers,
    // residue jumps and repeats, and raw noise atoms.
    task automatic queue_random_chains(input int n_items, input int max_seg);
        int          made;
        int          left;
        int          seg;
        int          k;
        int          pick;
        int          step;
        logic        noise;
        logic        tail;
        logic [7:0]  code;
        logic [15:0] res;
        made = 0;
        left = $urandom_range(40, 4);
        res  = 16'($urandom_range(300, 0));
        while (made < n_items)
        begin
            pick  = $urandom_range(99);
            noise = (pick < 8);
            if (noise)
            begin
                code = 8'($urandom_range(255));
                res  = 16'($urandom_range(65535));
                seg  = 1;
            end
            else if (pick < 20)
            begin
                case ($urandom_range(4))
                    0: code = ssrs_pkg::CODE_COIL;
                    1: code = ssrs_pkg::CODE_BRIDGE;
                    2: code = ssrs_pkg::CODE_BRIDGE_LC;
                    3: code = ssrs_pkg::CODE_TURN;
                    default: code = ssrs_pkg::CODE_DOT;
                endcase
                seg = $urandom_range(2, 1);
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 25)
                    code = ssrs_pkg::CODE_ALPHA;
                else if (pick < 40)
                    code = ssrs_pkg::CODE_THREE_TEN;
                else if (pick < 50)
                    code = ssrs_pkg::CODE_PI;
                else if (pick < 80)
                    code = CODE_STRAND;
                else
                    code = 8'($urandom_range(255));
                seg = $urandom_range(max_seg, 1);
                if ($urandom_range(9) == 0)
                    res = 16'($urandom_range(65535, 65530));
            end
            for (k = 0; k < seg && made < n_items; k++)
            begin
                step = $urandom_range(99);
                if (step < 84)
                    res = res + 16'd1;
                else if (step < 92 && step >= 89)
                    res = res - 16'd1;
                else if (step >= 92)
                    res = res + 16'($urandom_range(5, 2));
                left--;
                tail = (left <= 0) || (noise && $urandom_range(7) == 0);
                queue_atom(code, res, tail);
                made++;
                if (tail)
                begin
                    left = $urandom_range(40, 4);
                    res  = 16'($urandom_range(300, 0));
                end
            end
        end
    endtask

    // Waits until every atom is taken and every record is back, then lets the
    // pipeline empty of atoms that make no record.
    task automatic drain();
        do
            @(negedge clk);
        while (atoms_to_send.size() != 0 || in_valid);
        while (records_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_min_size(input logic [9:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        min_size_q  = value;
        @(negedge clk);
    endtask

    initial
    begin
        clear_chain();
        min_size_q = 10'd1;
        prev_res   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: code change, breakers, jumps, equal and falling residues, the
        // last residue number, and chain ends after a continued run, code change or jump.
        queue_atom(ssrs_pkg::CODE_ALPHA, 16'd10, 1'b0);
        queue_atom(ssrs_pkg::CODE_ALPHA, 16'd11, 1'b0);
        queue_atom(ssrs_pkg::CODE_ALPHA, 16'd12, 1'b0);
        queue_atom(CODE_STRAND, 16'd13, 1'b0);
        queue_atom(CODE_STRAND, 16'd14, 1'b0);
        queue_atom(ssrs_pkg::CODE_COIL, 16'd15, 1'b0);
        queue_atom(ssrs_pkg::CODE_THREE_TEN, 16'd20, 1'b0);
        queue_atom(ssrs_pkg::CODE_THREE_TEN, 16'd21, 1'b0);
        queue_atom(ssrs_pkg::CODE_THREE_TEN, 16'd25, 1'b0);
        queue_atom(ssrs_pkg::CODE_THREE_TEN, 16'd25, 1'b0);
        queue_atom(ssrs_pkg::CODE_THREE_TEN, 16'd24, 1'b0);
        queue_atom(ssrs_pkg::CODE_BRIDGE, 16'd26, 1'b0);
        queue_atom(ssrs_pkg::CODE_PI, 16'd27, 1'b0);
        queue_atom(ssrs_pkg::CODE_BRIDGE_LC, 16'd28, 1'b0);
        queue_atom(ssrs_pkg::CODE_TURN, 16'd29, 1'b0);
        queue_atom(ssrs_pkg::CODE_DOT, 16'd30, 1'b0);
        queue_atom(ssrs_pkg::CODE_PI, 16'd31, 1'b0);
        queue_atom(ssrs_pkg::CODE_PI, 16'd32, 1'b1);
        queue_atom(8'hFF, 16'd65534, 1'b0);
        queue_atom(8'hFF, 16'd65535, 1'b0);
        queue_atom(8'hFF, 16'd65535, 1'b1);
        queue_atom(8'h00, 16'd0, 1'b1);
        queue_atom(CODE_STRAND, 16'd1, 1'b0);
        queue_atom(ssrs_pkg::CODE_ALPHA, 16'd2, 1'b1);
        queue_atom(CODE_STRAND, 16'd5, 1'b0);
        queue_atom(CODE_STRAND, 16'd9, 1'b1);
        drain();

        write_min_size(10'd0);
        queue_random_chains(100, 4);
        drain();

        // Largest threshold: no run gets long enough to become an element.
        write_min_size(10'd1023);
        queue_random_chains(30, 4);
        drain();

        write_min_size(10'd2);
        queue_random_chains(120, 5);
        drain();

        write_min_size(10'd3);
        queue_random_chains(100, 6);
        drain();

        // No idling on either side from here on.
        write_min_size(10'd1);
        idle_pct = 0;
        queue_random_chains(80, 4);
        drain();

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ssrs_pkg.sv
hw/rtl/ssrs_front.sv
hw/rtl/ssrs_queue.sv
hw/rtl/ssrs_back.sv
hw/rtl/secondary_structure_run_segmenter.sv
tb/sv/secondary_structure_run_segmenter_tb.sv
